FILE: sv/mau_pkg.sv
// shared types, codes and helpers for the modular arithmetic unit
// no dependencies
package mau_pkg;

  localparam int MW = 31;
  localparam int DW = 64;
  localparam int CW = 7;

  typedef logic [MW-1:0] res_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_NEG = 3'd5,
    OP_RED = 3'd6,
    OP_NOP = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOINV  = 2'd1;
  localparam logic [1:0] ST_NEGEXP = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RA   = 11'b00000000010,
    S_RB   = 11'b00000000100,
    S_DISP = 11'b00000001000,
    S_MUL  = 11'b00000010000,
    S_EDIV = 11'b00000100000,
    S_EMUL = 11'b00001000000,
    S_PBIT = 11'b00010000000,
    S_PMUL = 11'b00100000000,
    S_PSQR = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic          go;
    logic [DW-1:0] src;
    logic [CW-1:0] nbits;
    res_t          d;
    res_t          addend;
  } ser_cmd_t;

  typedef struct packed {
    logic done;
    res_t acc;
    res_t quo;
  } ser_rsp_t;

  function automatic res_t mod_add(input res_t x, input res_t y, input res_t m);
    logic [MW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MW-1:0];
  endfunction

  function automatic res_t mod_sub(input res_t x, input res_t y, input res_t m);
    logic [MW:0] s;
    if (x >= y) begin
      s = {1'b0, x} - {1'b0, y};
    end else begin
      s = {1'b0, x} + {1'b0, m} - {1'b0, y};
    end
    return s[MW-1:0];
  endfunction

  function automatic res_t fix_neg(input logic neg, input res_t r, input res_t m);
    res_t o;
    o = r;
    if (neg && r != '0) begin
      o = m - r;
    end
    return o;
  endfunction

endpackage

FILE: sv/mau_serial.sv
// bit-serial shift-and-reduce unit: remainder, quotient and modular product
// depends on mau_pkg
module mau_serial (
  input  logic               clk,
  input  logic               rst,
  input  mau_pkg::ser_cmd_t  cmd,
  output mau_pkg::ser_rsp_t  rsp
);
  import mau_pkg::*;

  logic [DW-1:0] src;
  logic [CW-1:0] cnt;
  res_t          acc;
  res_t          quo;
  res_t          d;
  res_t          addend;
  logic          done;

  logic [MW+1:0] t;
  logic [MW+1:0] d1;
  logic [MW+1:0] d2;
  res_t          acc_next;

  always_comb begin
    t  = {1'b0, acc, 1'b0} + {2'b00, (src[DW-1] ? addend : '0)};
    d1 = {2'b00, d};
    d2 = {1'b0, d, 1'b0};
    if (t >= d2) begin
      acc_next = res_t'(t - d2);
    end else if (t >= d1) begin
      acc_next = res_t'(t - d1);
    end else begin
      acc_next = t[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (cmd.go) begin
        src    <= cmd.src;
        cnt    <= cmd.nbits;
        d      <= cmd.d;
        addend <= cmd.addend;
        acc    <= '0;
        quo    <= '0;
        done   <= 1'b0;
      end else if (cnt != '0) begin
        src  <= {src[DW-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        acc  <= acc_next;
        quo  <= {quo[MW-2:0], (t >= d1)};
        done <= (cnt == CW'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.acc  = acc;
  assign rsp.quo  = quo;

endmodule

FILE: sv/modular_arithmetic_unit.sv
// top level: sequencer of the modular arithmetic unit around one serial unit
// depends on mau_pkg and mau_serial
//
// channel   | handshake          | payload
// command   | start / busy       | op, a, b
// result    | done (strobe)      | result, status
// config    | cfg_we             | cfg_data
//
// each operand reduction shifts all 64 operand bits through the serial unit, a product all 31
// residue bits; one inverse step is a division plus a product, up to about 45 steps. power
// spends a product and a square on each set exponent bit and a square alone on each clear
// one up to its highest set bit. add, subtract, negate, reduce raise done after both operand
// reductions and the dispatch. reset returns to idle with modulus 998244353; results cannot stall
module modular_arithmetic_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           op,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_data,
  output logic                 done,
  output logic [30:0]          result,
  output logic [1:0]           status
);
  import mau_pkg::*;

  state_t        state;
  logic          issued;
  op_t           opr;
  logic [DW-1:0] ain;
  logic [DW-1:0] bin;
  res_t          modulus;
  res_t          ra;
  res_t          rb;
  res_t          e_ra;
  res_t          e_rm;
  res_t          eu;
  res_t          ev;
  res_t          eq;
  res_t          pres;
  res_t          px;
  logic [DW-2:0] pexp;
  res_t          mx;
  res_t          my;
  res_t          res_q;
  logic [1:0]    st_q;

  ser_cmd_t cmd;
  ser_rsp_t rsp;

  mau_serial u_ser (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always_comb begin
    cmd.go     = 1'b0;
    cmd.src    = '0;
    cmd.nbits  = CW'(MW);
    cmd.d      = modulus;
    cmd.addend = res_t'(1);
    unique case (state)
      S_RA: begin
        cmd.go    = !issued;
        cmd.src   = ain[DW-1] ? (~ain + 1'b1) : ain;
        cmd.nbits = CW'(DW);
      end
      S_RB: begin
        cmd.go    = !issued;
        cmd.src   = bin[DW-1] ? (~bin + 1'b1) : bin;
        cmd.nbits = CW'(DW);
      end
      S_MUL: begin
        cmd.go     = !issued;
        cmd.src    = {my, {(DW-MW){1'b0}}};
        cmd.addend = mx;
      end
      S_EDIV: begin
        cmd.go  = !issued && e_ra != '0;
        cmd.src = {e_rm, {(DW-MW){1'b0}}};
        cmd.d   = e_ra;
      end
      S_EMUL: begin
        cmd.go     = !issued;
        cmd.src    = {eq, {(DW-MW){1'b0}}};
        cmd.addend = ev;
      end
      S_PMUL: begin
        cmd.go     = !issued;
        cmd.src    = {px, {(DW-MW){1'b0}}};
        cmd.addend = pres;
      end
      S_PSQR: begin
        cmd.go     = !issued;
        cmd.src    = {px, {(DW-MW){1'b0}}};
        cmd.addend = px;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issued  <= 1'b0;
      modulus <= res_t'(998244353);
    end else begin
      if (cmd.go) begin
        issued <= 1'b1;
      end else if (rsp.done) begin
        issued <= 1'b0;
      end
      if (cfg_we) begin
        modulus <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            opr <= op_t'(op);
            ain <= a;
            bin <= b;
            if (modulus == '0) begin
              res_q <= '0;
              st_q  <= ST_OK;
              state <= S_DONE;
            end else begin
              state <= S_RA;
            end
          end
        end
        S_RA: begin
          if (rsp.done) begin
            ra    <= fix_neg(ain[DW-1], rsp.acc, modulus);
            state <= S_RB;
          end
        end
        S_RB: begin
          if (rsp.done) begin
            rb    <= fix_neg(bin[DW-1], rsp.acc, modulus);
            state <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (opr)
            OP_ADD: begin
              res_q <= mod_add(ra, rb, modulus);
              st_q  <= ST_OK;
              state <= S_DONE;
            end
            OP_SUB: begin
              res_q <= mod_sub(ra, rb, modulus);
              st_q  <= ST_OK;
              state <= S_DONE;
            end
            OP_MUL: begin
              mx    <= ra;
              my    <= rb;
              state <= S_MUL;
            end
            OP_DIV: begin
              e_rm  <= modulus;
              e_ra  <= rb;
              eu    <= '0;
              ev    <= (modulus == res_t'(1)) ? '0 : res_t'(1);
              state <= S_EDIV;
            end
            OP_POW: begin
              if (bin[DW-1]) begin
                res_q <= '0;
                st_q  <= ST_NEGEXP;
                state <= S_DONE;
              end else begin
                pres  <= (modulus == res_t'(1)) ? '0 : res_t'(1);
                px    <= ra;
                pexp  <= bin[DW-2:0];
                state <= S_PBIT;
              end
            end
            OP_NEG: begin
              res_q <= mod_sub('0, ra, modulus);
              st_q  <= ST_OK;
              state <= S_DONE;
            end
            OP_RED: begin
              res_q <= ra;
              st_q  <= ST_OK;
              state <= S_DONE;
            end
            OP_NOP: begin
              res_q <= '0;
              st_q  <= ST_OK;
              state <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          if (rsp.done) begin
            res_q <= rsp.acc;
            st_q  <= ST_OK;
            state <= S_DONE;
          end
        end
        S_EDIV: begin
          if (!issued && e_ra == '0) begin
            if (e_rm == res_t'(1)) begin
              mx    <= ra;
              my    <= eu;
              state <= S_MUL;
            end else begin
              res_q <= '0;
              st_q  <= ST_NOINV;
              state <= S_DONE;
            end
          end else if (rsp.done) begin
            eq    <= rsp.quo;
            e_rm  <= e_ra;
            e_ra  <= rsp.acc;
            state <= S_EMUL;
          end
        end
        S_EMUL: begin
          if (rsp.done) begin
            eu    <= ev;
            ev    <= mod_sub(eu, rsp.acc, modulus);
            state <= S_EDIV;
          end
        end
        S_PBIT: begin
          if (pexp == '0) begin
            res_q <= pres;
            st_q  <= ST_OK;
            state <= S_DONE;
          end else if (pexp[0]) begin
            state <= S_PMUL;
          end else begin
            state <= S_PSQR;
          end
        end
        S_PMUL: begin
          if (rsp.done) begin
            pres  <= rsp.acc;
            state <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (rsp.done) begin
            px    <= rsp.acc;
            pexp  <= {1'b0, pexp[DW-2:1]};
            state <= S_PBIT;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign result = res_q;
  assign status = st_q;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("no return to idle after result beat");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted command did not go busy");

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    (done && modulus != '0) |-> result < modulus) else $error("result not reduced");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> result == '0) else $error("error beat with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NOINV || status == ST_NEGEXP))
    else $error("bad status code");

endmodule
